// ----- rtl/tank_level_heat_controller_top_defines.svh -----
// Assertion macros for the tank level and heating controller checker.
`ifndef TANK_LEVEL_HEAT_CONTROLLER_TOP_DEFINES_SVH
`define TANK_LEVEL_HEAT_CONTROLLER_TOP_DEFINES_SVH

// Clocked property, ignored while reset is high.
`define TLHC_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("tlhc checker: property failed");

// Overlapping implication form.
`define TLHC_ASSERT_IMPL(label, ante, cons) \
  `TLHC_ASSERT(label, (ante) |-> (cons))

`endif

// ----- rtl/tlhc_pkg.sv -----
// Types and constants shared by the tank level and heating controller.
`timescale 1ns / 1ps
package tlhc_pkg;

  localparam int unsigned ADDR_W = 5;

  // Register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_LEVEL_EMPTY  = 3'd0;
  localparam logic [2:0] REG_LEVEL_FULL   = 3'd1;
  localparam logic [2:0] REG_LEVEL_TARGET = 3'd2;
  localparam logic [2:0] REG_TEMP_LOW     = 3'd3;
  localparam logic [2:0] REG_TEMP_TARGET  = 3'd4;

  // Sensor kinds
  localparam logic [1:0] KIND_TEMP  = 2'd0;
  localparam logic [1:0] KIND_LEVEL = 2'd1;

  // Mode codes as seen on the output
  localparam logic [2:0] MODE_CODE_IDLE     = 3'd0;
  localparam logic [2:0] MODE_CODE_FILLING  = 3'd1;
  localparam logic [2:0] MODE_CODE_DRAINING = 3'd2;
  localparam logic [2:0] MODE_CODE_HEATING  = 3'd3;
  localparam logic [2:0] MODE_CODE_MANUAL   = 3'd4;
  localparam logic [2:0] MODE_CODE_ERROR    = 3'd5;

  typedef enum logic [5:0] {
    MODE_IDLE     = 6'b000001,
    MODE_FILLING  = 6'b000010,
    MODE_DRAINING = 6'b000100,
    MODE_HEATING  = 6'b001000,
    MODE_MANUAL   = 6'b010000,
    MODE_ERROR    = 6'b100000
  } mode_t;

  typedef struct packed {
    logic [14:0] level_empty;
    logic [14:0] level_full;
    logic [14:0] level_target;
    logic signed [15:0] temp_low;
    logic signed [15:0] temp_target;
  } cfg_t;

  // Stored sensor context
  typedef struct packed {
    logic signed [15:0] last_temp;
    logic signed [15:0] last_level;
    logic temp_seen;
    logic temp_good;
    logic level_seen;
    logic level_good;
  } ctx_t;

  function automatic logic [2:0] mode_code(mode_t m);
    logic [2:0] c;
    unique case (m)
      MODE_IDLE:     c = MODE_CODE_IDLE;
      MODE_FILLING:  c = MODE_CODE_FILLING;
      MODE_DRAINING: c = MODE_CODE_DRAINING;
      MODE_HEATING:  c = MODE_CODE_HEATING;
      MODE_MANUAL:   c = MODE_CODE_MANUAL;
      MODE_ERROR:    c = MODE_CODE_ERROR;
      default:       c = MODE_CODE_IDLE;
    endcase
    return c;
  endfunction

endpackage

// ----- rtl/tlhc_step.sv -----
// Context update and one controller transition for a single sensor word.
`timescale 1ns / 1ps
module tlhc_step (
  input  tlhc_pkg::cfg_t         cfg,
  input  tlhc_pkg::ctx_t         ctx,
  input  tlhc_pkg::mode_t        mode,
  input  logic [1:0]             kind,
  input  logic                   reading_ok,
  input  logic signed [15:0]     reading,
  output tlhc_pkg::ctx_t         ctx_next,
  output tlhc_pkg::mode_t        mode_next
);
  import tlhc_pkg::*;

  logic               fault;
  logic signed [15:0] lvl_empty_s;
  logic signed [15:0] lvl_full_s;
  logic signed [15:0] lvl_target_s;

  // Level thresholds are unsigned 15 bit, so zero-extend into signed compares
  assign lvl_empty_s  = $signed({1'b0, cfg.level_empty});
  assign lvl_full_s   = $signed({1'b0, cfg.level_full});
  assign lvl_target_s = $signed({1'b0, cfg.level_target});

  always_comb begin
    ctx_next = ctx;
    if (kind == KIND_TEMP) begin
      ctx_next.temp_seen = 1'b1;
      ctx_next.temp_good = reading_ok;
      if (reading_ok) ctx_next.last_temp = reading;
    end else if (kind == KIND_LEVEL) begin
      ctx_next.level_seen = 1'b1;
      ctx_next.level_good = reading_ok;
      if (reading_ok) ctx_next.last_level = reading;
    end
  end

  assign fault = (ctx_next.temp_seen && !ctx_next.temp_good) ||
                 (ctx_next.level_seen && !ctx_next.level_good);

  always_comb begin
    mode_next = mode;
    unique case (mode)
      MODE_IDLE: begin
        priority if (fault) mode_next = MODE_ERROR;
        else if (!(ctx_next.temp_seen && ctx_next.level_seen)) mode_next = MODE_IDLE;
        else if (ctx_next.last_level > lvl_empty_s) mode_next = MODE_FILLING;
        else if (ctx_next.last_level < lvl_full_s) mode_next = MODE_DRAINING;
        else if (ctx_next.last_temp < cfg.temp_low) mode_next = MODE_HEATING;
        else mode_next = MODE_IDLE;
      end
      MODE_FILLING: begin
        priority if (fault) mode_next = MODE_ERROR;
        else if (ctx_next.last_level <= lvl_target_s) mode_next = MODE_IDLE;
        else mode_next = MODE_FILLING;
      end
      MODE_DRAINING: begin
        priority if (fault) mode_next = MODE_ERROR;
        else if (ctx_next.last_level >= lvl_target_s) mode_next = MODE_IDLE;
        else mode_next = MODE_DRAINING;
      end
      MODE_HEATING: begin
        priority if (fault) mode_next = MODE_ERROR;
        else if (ctx_next.last_temp >= cfg.temp_target) mode_next = MODE_IDLE;
        else mode_next = MODE_HEATING;
      end
      MODE_MANUAL: mode_next = fault ? MODE_ERROR : MODE_MANUAL;
      MODE_ERROR:  mode_next = fault ? MODE_ERROR : MODE_IDLE;
      default:     mode_next = MODE_IDLE;
    endcase
  end

endmodule

// ----- rtl/tank_level_heat_controller_top.sv -----
// Top level of the tank level and heating controller.
`timescale 1ns / 1ps
// Takes one sensor word per cycle (temperature, level distance or luminosity,
// each with a valid flag) and returns one word per input: the controller mode
// and the fill pump, drain pump and heater drive bits. The accepting edge
// loads the input register; the context update and mode transition then
// land in the result register, which drives m_tvalid. Throughput is one
// word per clock unless the sink stalls, as context and mode update with
// each word. s_tready only drops while both the input register and the
// result register are full and the sink is stalling.
// Thresholds sit in five APB registers at byte addresses
// 0x00 level_empty, 0x04 level_full, 0x08 level_target, 0x0C temp_low,
// 0x10 temp_target; write them only while no word is in flight. Readings are
// in hundredths of a degree or centimetre. Luminosity words, and kind code
// three, trigger an evaluation but leave the stored context untouched.
module tank_level_heat_controller_top (
  input  logic                          clk,
  input  logic                          rst,
  // sensor words in
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [15:0]                   s_tdata,  // [15:0] reading
  input  logic [2:0]                    s_tuser,  // [1:0] kind, [2] reading_ok
  // result words out
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [7:0]                    m_tdata,  // [2:0] mode, [3] fill_on,
                                                  // [4] drain_on, [5] heater_on
  // APB configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tlhc_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import tlhc_pkg::*;

  cfg_t  cfg;
  ctx_t  ctx;
  ctx_t  ctx_next;
  mode_t mode;
  mode_t mode_next;

  // input register
  logic               in_valid;
  logic [1:0]         in_kind;
  logic               in_ok;
  logic signed [15:0] in_reading;

  logic       advance;
  logic [2:0] reg_idx;
  logic       cfg_wr;
  logic [2:0] code_next;

  // --- config port ---
  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.level_empty  <= 15'd2500;
      cfg.level_full   <= 15'd800;
      cfg.level_target <= 15'd1400;
      cfg.temp_low     <= 16'sd2400;
      cfg.temp_target  <= 16'sd2600;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_LEVEL_EMPTY:  cfg.level_empty  <= pwdata[14:0];
        REG_LEVEL_FULL:   cfg.level_full   <= pwdata[14:0];
        REG_LEVEL_TARGET: cfg.level_target <= pwdata[14:0];
        REG_TEMP_LOW:     cfg.temp_low     <= $signed(pwdata[15:0]);
        REG_TEMP_TARGET:  cfg.temp_target  <= $signed(pwdata[15:0]);
        default: ;  // unmapped, write ignored
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_LEVEL_EMPTY:  prdata = {17'd0, cfg.level_empty};
      REG_LEVEL_FULL:   prdata = {17'd0, cfg.level_full};
      REG_LEVEL_TARGET: prdata = {17'd0, cfg.level_target};
      REG_TEMP_LOW:     prdata = {16'd0, cfg.temp_low};
      REG_TEMP_TARGET:  prdata = {16'd0, cfg.temp_target};
      default:          prdata = 32'd0;
    endcase
  end

  // --- handshake ---
  // Result register moves on when empty or being taken; input register
  // refills whenever it is empty or empties into it.
  assign advance  = !m_tvalid || m_tready;
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_kind    <= s_tuser[1:0];
      in_ok      <= s_tuser[2];
      in_reading <= $signed(s_tdata);
    end
  end

  // --- evaluation ---
  tlhc_step u_step (
    .cfg        (cfg),
    .ctx        (ctx),
    .mode       (mode),
    .kind       (in_kind),
    .reading_ok (in_ok),
    .reading    (in_reading),
    .ctx_next   (ctx_next),
    .mode_next  (mode_next)
  );

  assign code_next = mode_code(mode_next);

  // context and mode move only when a word passes into the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_IDLE;
      ctx  <= '0;
    end else if (in_valid && advance) begin
      mode <= mode_next;
      ctx  <= ctx_next;
    end
  end

  // --- result register ---
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      m_tdata <= {2'b00,
                  (mode_next == MODE_HEATING),
                  (mode_next == MODE_DRAINING),
                  (mode_next == MODE_FILLING),
                  code_next};
    end
  end

endmodule

// ----- rtl/tlhc_checker.sv -----
// Port-level checks for the tank level and heating controller, with bind.
`timescale 1ns / 1ps
`include "tank_level_heat_controller_top_defines.svh"
module tlhc_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata
);
  import tlhc_pkg::*;

  // at most one actuator driven
  `TLHC_ASSERT_IMPL(a_one_drive, m_tvalid, $countones(m_tdata[5:3]) <= 1)
  // fill pump follows the filling mode
  `TLHC_ASSERT_IMPL(a_fill_mode, m_tvalid, m_tdata[3] == (m_tdata[2:0] == MODE_CODE_FILLING))
  // heater follows the heating mode
  `TLHC_ASSERT_IMPL(a_heat_mode, m_tvalid, m_tdata[5] == (m_tdata[2:0] == MODE_CODE_HEATING))
  // an accepted word reaches the output if the sink is ready just after it
  `TLHC_ASSERT(a_latency, (s_tvalid && s_tready) ##1 m_tready |=> m_tvalid)
  // stalled result holds
  `TLHC_ASSERT(a_hold, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))

endmodule

bind tank_level_heat_controller_top tlhc_checker u_tlhc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ----- tb/tank_level_heat_controller_top_test.sv -----
// Self-checking testbench for the tank level and heating controller top level.
`timescale 1ns / 1ps
module tank_level_heat_controller_top_test;
  import tlhc_pkg::*;

  // Kind codes the package leaves out: luminosity and the spare code,
  // both of which only trigger an evaluation.
  localparam logic [1:0] KIND_LIGHT = 2'd2;
  localparam logic [1:0] KIND_SPARE = 2'd3;

  localparam int SEGMENTS     = 7;
  localparam int SEGMENT_LEN  = 200;
  localparam int HOLD_CYCLES  = 400;   // long sink stall, fills the pipe
  localparam int SETTLE       = 6;     // margin after the last result

  // One row of the opening sequence; typed rows carry a mode read straight
  // off the transition rules, the rest are left to the predictor.
  typedef struct packed {
    logic [1:0]  kind;
    logic        ok;
    logic [15:0] reading;
    logic        typed;
    logic [2:0]  mode;
  } sensor_probe_t;

  localparam int OPENING_LEN = 26;
  localparam sensor_probe_t OPENING_WORDS [OPENING_LEN] = '{
    '{KIND_LIGHT, 1'b0, 16'h8000, 1'b1, MODE_CODE_IDLE},     // nothing seen yet
    '{KIND_TEMP,  1'b1, 16'h7FFF, 1'b1, MODE_CODE_IDLE},     // level still unseen
    '{KIND_LEVEL, 1'b1, 16'h8000, 1'b1, MODE_CODE_DRAINING}, // lowest distance
    '{KIND_LEVEL, 1'b1, 16'd1400,  1'b0, MODE_CODE_IDLE},     // drain ends on target
    '{KIND_LEVEL, 1'b1, 16'h7FFF, 1'b1, MODE_CODE_FILLING},  // highest distance
    '{KIND_SPARE, 1'b1, 16'h0000, 1'b0, MODE_CODE_IDLE},     // spare kind, no update
    '{KIND_LEVEL, 1'b0, 16'h0000, 1'b1, MODE_CODE_ERROR},    // bad level reading
    '{KIND_LIGHT, 1'b1, 16'h7FFF, 1'b1, MODE_CODE_ERROR},    // fault still held
    '{KIND_LEVEL, 1'b1, 16'd1400,  1'b0, MODE_CODE_IDLE},     // recovery
    '{KIND_TEMP,  1'b1, 16'h8000, 1'b0, MODE_CODE_IDLE},     // coldest, heat
    '{KIND_TEMP,  1'b1, 16'd2599,  1'b0, MODE_CODE_IDLE},     // just short of target
    '{KIND_TEMP,  1'b0, 16'h7FFF, 1'b1, MODE_CODE_ERROR},    // bad temperature
    '{KIND_TEMP,  1'b1, 16'd2600,  1'b0, MODE_CODE_IDLE},
    '{KIND_LIGHT, 1'b0, 16'h1234, 1'b0, MODE_CODE_IDLE},
    '{KIND_LEVEL, 1'b1, 16'd2500,  1'b0, MODE_CODE_IDLE},     // on the empty mark
    '{KIND_LEVEL, 1'b1, 16'd2501,  1'b0, MODE_CODE_IDLE},     // one past it
    '{KIND_LEVEL, 1'b1, 16'd1401,  1'b0, MODE_CODE_IDLE},
    '{KIND_LEVEL, 1'b1, 16'd1400,  1'b0, MODE_CODE_IDLE},
    '{KIND_LEVEL, 1'b1, 16'd799,   1'b0, MODE_CODE_IDLE},     // just under full mark
    '{KIND_LEVEL, 1'b1, 16'd1399,  1'b0, MODE_CODE_IDLE},
    '{KIND_TEMP,  1'b0, 16'd100,   1'b1, MODE_CODE_ERROR},    // stored value kept
    '{KIND_LIGHT, 1'b1, 16'h0000, 1'b1, MODE_CODE_ERROR},
    '{KIND_LEVEL, 1'b0, 16'd5,     1'b1, MODE_CODE_ERROR},    // both sensors bad
    '{KIND_TEMP,  1'b1, 16'd2399,  1'b1, MODE_CODE_ERROR},    // level still bad
    '{KIND_LEVEL, 1'b1, 16'd800,   1'b0, MODE_CODE_IDLE},     // on the full mark
    '{KIND_LIGHT, 1'b0, 16'hFFFF, 1'b0, MODE_CODE_IDLE}      // heat from idle
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata = '0;   // [15:0] reading
  logic [2:0]  s_tuser = '0;   // [1:0] kind, [2] reading_ok
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;        // [2:0] mode, [3] fill_on, [4] drain_on, [5] heater_on
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  tank_level_heat_controller_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Predictor copy of the thresholds and controller context.
  logic [14:0]        thr_empty       = 15'd2500;
  logic [14:0]        thr_full        = 15'd800;
  logic [14:0]        thr_target      = 15'd1400;
  logic signed [15:0] thr_temp_low    = 16'sd2400;
  logic signed [15:0] thr_temp_target = 16'sd2600;

  logic [2:0]         ctl_mode    = MODE_CODE_IDLE;
  logic signed [15:0] held_temp   = '0;
  logic signed [15:0] held_level  = '0;
  logic               temp_rx     = 1'b0;
  logic               temp_valid  = 1'b0;
  logic               level_rx    = 1'b0;
  logic               level_ok    = 1'b0;

  logic [7:0] pending_results [$];   // expected result words, oldest first
  int         mismatches = 0;

  int  send_idle_pct = 36;
  int  recv_idle_pct = 64;
  bit  hold_req = 1'b0;

  // Updates the context with one sensor word and steps the controller.
  function automatic logic [2:0] next_tank_mode(input logic [1:0] kind, input logic ok,
                                                input logic [15:0] reading);
    logic fault;
    logic [2:0] nxt;
    int lvl;
    int tmp;
    if (kind == KIND_TEMP) begin
      temp_rx = 1'b1;
      temp_valid = ok;
      if (ok) held_temp = reading;
    end else if (kind == KIND_LEVEL) begin
      level_rx = 1'b1;
      level_ok = ok;
      if (ok) held_level = reading;
    end
    fault = (temp_rx && !temp_valid) || (level_rx && !level_ok);
    lvl = int'(held_level);
    tmp = int'(held_temp);
    case (ctl_mode)
      MODE_CODE_IDLE: begin
        if (fault) nxt = MODE_CODE_ERROR;
        else if (!(temp_rx && level_rx)) nxt = MODE_CODE_IDLE;
        else if (lvl > int'(thr_empty)) nxt = MODE_CODE_FILLING;
        else if (lvl < int'(thr_full)) nxt = MODE_CODE_DRAINING;
        else if (tmp < int'(thr_temp_low)) nxt = MODE_CODE_HEATING;
        else nxt = MODE_CODE_IDLE;
      end
      MODE_CODE_FILLING: begin
        if (fault) nxt = MODE_CODE_ERROR;
        else nxt = (lvl <= int'(thr_target)) ? MODE_CODE_IDLE : MODE_CODE_FILLING;
      end
      MODE_CODE_DRAINING: begin
        if (fault) nxt = MODE_CODE_ERROR;
        else nxt = (lvl >= int'(thr_target)) ? MODE_CODE_IDLE : MODE_CODE_DRAINING;
      end
      MODE_CODE_HEATING: begin
        if (fault) nxt = MODE_CODE_ERROR;
        else nxt = (tmp >= int'(thr_temp_target)) ? MODE_CODE_IDLE : MODE_CODE_HEATING;
      end
      MODE_CODE_MANUAL: nxt = fault ? MODE_CODE_ERROR : MODE_CODE_MANUAL;
      MODE_CODE_ERROR:  nxt = fault ? MODE_CODE_ERROR : MODE_CODE_IDLE;
      default:          nxt = MODE_CODE_IDLE;
    endcase
    ctl_mode = nxt;
    return nxt;
  endfunction

  // Readings mostly hug a live threshold so every compare flips both ways.
  function automatic logic [15:0] pick_reading(input logic [1:0] kind);
    int sel;
    int pivot;
    sel = $urandom_range(0, 9);
    if (sel == 8) return 16'h8000;
    if (sel == 9) return 16'h7FFF;
    if (sel >= 6) return 16'($urandom);
    if (kind == KIND_TEMP) begin
      pivot = ($urandom_range(0, 1) != 0) ? int'(thr_temp_low) : int'(thr_temp_target);
    end else begin
      case ($urandom_range(0, 2))
        0:       pivot = int'(thr_empty);
        1:       pivot = int'(thr_full);
        default: pivot = int'(thr_target);
      endcase
    end
    return 16'(pivot + int'($urandom_range(0, 8)) - 4);
  endfunction

  // Offers one word, waits for the handshake, then books its result.
  // Each call starts just after a rising edge.
  task automatic offer_sensor_word(input logic [1:0] kind, input logic ok,
                                   input logic [15:0] reading, input logic typed,
                                   input logic [2:0] typed_mode);
    logic [2:0] mode;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= reading;
    s_tuser  <= {ok, kind};
    do @(posedge clk); while (!s_tready);
    mode = next_tank_mode(kind, ok, reading);
    if (typed) mode = typed_mode;
    pending_results.push_back({2'b00, mode == MODE_CODE_HEATING,
                               mode == MODE_CODE_DRAINING, mode == MODE_CODE_FILLING, mode});
  endtask

  // Stop offering and let every booked result come back.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // APB write: setup phase, access phase, then the bus is released.
  task automatic write_threshold(input logic [2:0] idx, input int value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'h0000, 16'(value)};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_LEVEL_EMPTY:  thr_empty       = value[14:0];
      REG_LEVEL_FULL:   thr_full        = value[14:0];
      REG_LEVEL_TARGET: thr_target      = value[14:0];
      REG_TEMP_LOW:     thr_temp_low    = value[15:0];
      REG_TEMP_TARGET:  thr_temp_target = value[15:0];
      default: ;
    endcase
  endtask

  task automatic apply_thresholds(input int empty_mark, input int full_mark,
                                  input int target_mark, input int low_temp,
                                  input int target_temp);
    write_threshold(REG_LEVEL_EMPTY, empty_mark);
    write_threshold(REG_LEVEL_FULL, full_mark);
    write_threshold(REG_LEVEL_TARGET, target_mark);
    write_threshold(REG_TEMP_LOW, low_temp);
    write_threshold(REG_TEMP_TARGET, target_temp);
  endtask

  task automatic report_field(input string field, input int want, input int got);
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
    mismatches++;
  endtask

  // Sink side: random back-pressure, plus one long hold on request.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Result checker: each accepted word against the oldest expectation.
  always @(posedge clk) begin
    logic [7:0] want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result word, expected none, got %h", $time, m_tdata);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (m_tdata[2:0] !== want[2:0]) report_field("mode", want[2:0], m_tdata[2:0]);
        if (m_tdata[3] !== want[3]) report_field("fill_on", want[3], m_tdata[3]);
        if (m_tdata[4] !== want[4]) report_field("drain_on", want[4], m_tdata[4]);
        if (m_tdata[5] !== want[5]) report_field("heater_on", want[5], m_tdata[5]);
      end
    end
  end

  // Stimulus: opening sequence at reset thresholds, then random segments,
  // each under a threshold set and idling pattern chosen by its index.
  initial begin
    int full_mark;
    int target_mark;
    int low_temp;
    int pick;
    logic [1:0] kind;
    logic ok;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (OPENING_WORDS[i])
      offer_sensor_word(OPENING_WORDS[i].kind, OPENING_WORDS[i].ok,
                        OPENING_WORDS[i].reading, OPENING_WORDS[i].typed,
                        OPENING_WORDS[i].mode);
    wait_drained();

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      // sender idles 36 / sink 64, then swapped, then no idling at all
      if (seg < 2) begin
        send_idle_pct = 36;
        recv_idle_pct = 64;
      end else if (seg < 4) begin
        send_idle_pct = 64;
        recv_idle_pct = 36;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end

      case (seg)
        1, 4: begin
          // ordered marks: full below target below empty
          full_mark   = $urandom_range(0, 10000);
          target_mark = full_mark + $urandom_range(1, 5000);
          low_temp    = int'($urandom_range(0, 6000)) - 3000;
          apply_thresholds(target_mark + $urandom_range(1, 5000), full_mark, target_mark,
                           low_temp, low_temp + $urandom_range(1, 2000));
        end
        2:       apply_thresholds(32767, 32767, 32767, 32767, 32767);
        3:       apply_thresholds(0, 0, 0, -32768, -32768);
        5:       apply_thresholds(0, 32767, 16384, -32768, 32767);
        default: apply_thresholds(2500, 800, 1400, 2400, 2600);
      endcase

      for (int n = 0; n < SEGMENT_LEN; n++) begin
        if (seg == 4 && n == 60) hold_req = 1'b1;
        pick = $urandom_range(0, 99);
        if (pick < 40)      kind = KIND_TEMP;
        else if (pick < 80) kind = KIND_LEVEL;
        else if (pick < 90) kind = KIND_LIGHT;
        else                kind = KIND_SPARE;
        ok = ($urandom_range(0, 99) < 92);
        offer_sensor_word(kind, ok, pick_reading(kind), 1'b0, MODE_CODE_IDLE);
      end
      wait_drained();
    end

    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/tlhc_pkg.sv
rtl/tlhc_step.sv
rtl/tank_level_heat_controller_top.sv
rtl/tlhc_checker.sv
tb/tank_level_heat_controller_top_test.sv
